// ===== hw/rtl/pipct_pkg.sv =====
// ----------------------------------------------------------------------------
// pipct_pkg
// Shared constants and types for the point-in-polygon crossing test core.
// ----------------------------------------------------------------------------
package pipct_pkg;

	localparam int MAX_SIDES = 16;
	localparam int SLOT_W    = 4;
	localparam int ADDR_W    = $clog2(MAX_SIDES);
	localparam int SIDES_W   = 5;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		OP_VERTEX = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [SLOT_W-1:0]          slot;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== hw/rtl/pipct_front.sv =====
// ----------------------------------------------------------------------------
// pipct_front
// Input stage: takes items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module pipct_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 kind,
	input  logic [pipct_pkg::SLOT_W-1:0]         vertex_slot,
	input  logic signed [pipct_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pipct_pkg::COORD_W-1:0] coord_y,
	input  pipct_pkg::q_stat_t                   stat,
	output logic                                 busy,
	output logic                                 push,
	output pipct_pkg::item_t                     item
);
	import pipct_pkg::*;

	logic  hold_q;
	item_t item_q;
	logic  accept;
	logic  keep;
	op_t   op_in;

	// drop vertex writes to slots beyond the store
	always_comb begin
		op_in = (kind == 1'b1) ? OP_QUERY : OP_VERTEX;
		keep  = (op_in == OP_QUERY) ||
			((SIDES_W + 1)'(vertex_slot) < (SIDES_W + 1)'(MAX_SIDES));
	end

	assign busy   = hold_q && stat.full;
	assign accept = start && !busy;
	assign push   = hold_q && !stat.full;
	assign item   = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (accept) begin
			hold_q <= keep;
		end else if (push) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op   <= op_in;
			item_q.slot <= vertex_slot;
			item_q.x    <= coord_x;
			item_q.y    <= coord_y;
		end
	end

endmodule

// ===== hw/rtl/pipct_queue.sv =====
// ----------------------------------------------------------------------------
// pipct_queue
// Short item queue between the input stage and the edge walker.
// ----------------------------------------------------------------------------
module pipct_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pipct_pkg::item_t   wr_item,
	input  logic               pop,
	output pipct_pkg::item_t   head,
	output pipct_pkg::q_stat_t stat
);
	import pipct_pkg::*;

	logic [Q_CNT_W-1:0] cnt_q;
	logic [Q_PTR_W-1:0] wp_q;
	logic [Q_PTR_W-1:0] rp_q;
	item_t              slots_q [Q_DEPTH];

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head       = slots_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wp_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue popped while empty");

endmodule

// ===== hw/rtl/pipct_back.sv =====
// ----------------------------------------------------------------------------
// pipct_back
// Vertex store and edge walker: one edge per cycle through a product pipeline.
// ----------------------------------------------------------------------------
module pipct_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pipct_pkg::item_t                  head,
	input  pipct_pkg::q_stat_t                stat,
	input  logic [pipct_pkg::SIDES_W-1:0]     sides,
	output logic                              pop,
	output logic                              done,
	output logic                              inside_res
);
	import pipct_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]               state_q;
	logic [SIDES_W-1:0]       n_q;
	logic [SIDES_W-1:0]       k_q;
	logic [SIDES_W-1:0]       n_in;
	logic [SIDES_W-1:0]       rd_idx;
	logic                     rd_en;
	logic                     wr_en;
	logic                     q_start;

	logic signed [COORD_W-1:0] mem_x [MAX_SIDES];
	logic signed [COORD_W-1:0] mem_y [MAX_SIDES];
	logic signed [COORD_W-1:0] qx_q;
	logic signed [COORD_W-1:0] qy_q;

	// read stage
	logic                      v_s1, first_s1, last_s1;
	logic signed [COORD_W-1:0] xi_s1, yi_s1;
	logic signed [COORD_W-1:0] xj_q, yj_q;

	// difference stage
	logic                      v_s2, cand_s2, dypos_s2, last_s2;
	logic signed [DIFF_W-1:0]  dyl_s2, dxe_s2, dxq_s2, dy_s2;

	// product stage
	logic                      v_s3, cand_s3, dypos_s3, last_s3;
	logic signed [PROD_W-1:0]  pl_s3, pr_s3;

	logic                      parity_q;
	logic                      done_q;
	logic                      inside_q;
	logic                      left;
	logic                      toggle;
	logic                      straddle;
	logic                      xnear;

	assign n_in    = (sides > SIDES_W'(MAX_SIDES)) ? SIDES_W'(MAX_SIDES) : sides;
	assign pop     = (state_q == ST_IDLE) && !stat.empty;
	assign wr_en   = pop && (head.op == OP_VERTEX);
	assign q_start = pop && (head.op == OP_QUERY);
	assign rd_en   = (state_q == ST_WALK);
	// previous vertex of edge 0 is the last one; then walk 0 .. n-1
	assign rd_idx  = (k_q == '0) ? (n_q - 1'b1) : (k_q - 1'b1);

	assign done       = done_q;
	assign inside_res = inside_q;

	// vertex store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[head.slot[ADDR_W-1:0]] <= head.x;
			mem_y[head.slot[ADDR_W-1:0]] <= head.y;
		end
		if (rd_en) begin
			xi_s1 <= mem_x[rd_idx[ADDR_W-1:0]];
			yi_s1 <= mem_y[rd_idx[ADDR_W-1:0]];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_start && (n_in != '0)) begin
						n_q     <= n_in;
						k_q     <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_start) begin
			qx_q <= head.x;
			qy_q <= head.y;
		end
	end

	// edge classification from current and previous vertex
	always_comb begin
		straddle = ((yi_s1 < qy_q) && (yj_q >= qy_q)) ||
			((yj_q < qy_q) && (yi_s1 >= qy_q));
		xnear    = (xi_s1 <= qx_q) || (xj_q <= qx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			v_s3     <= 1'b0;
			last_s3  <= 1'b0;
		end else begin
			v_s1     <= rd_en;
			first_s1 <= (k_q == '0);
			last_s1  <= (k_q == n_q);
			v_s2     <= v_s1 && !first_s1;
			last_s2  <= last_s1;
			v_s3     <= v_s2;
			last_s3  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			xj_q <= xi_s1;
			yj_q <= yi_s1;
		end
		cand_s2  <= straddle && xnear;
		dypos_s2 <= (yj_q > yi_s1);
		dyl_s2   <= $signed({qy_q[COORD_W-1], qy_q}) - $signed({yi_s1[COORD_W-1], yi_s1});
		dxe_s2   <= $signed({xj_q[COORD_W-1], xj_q}) - $signed({xi_s1[COORD_W-1], xi_s1});
		dxq_s2   <= $signed({qx_q[COORD_W-1], qx_q}) - $signed({xi_s1[COORD_W-1], xi_s1});
		dy_s2    <= $signed({yj_q[COORD_W-1], yj_q}) - $signed({yi_s1[COORD_W-1], yi_s1});
		cand_s3  <= cand_s2;
		dypos_s3 <= dypos_s2;
		pl_s3    <= PROD_W'(dyl_s2) * PROD_W'(dxe_s2);
		pr_s3    <= PROD_W'(dxq_s2) * PROD_W'(dy_s2);
	end

	// crossing lies left of the query when the products compare the right way
	assign left   = dypos_s3 ? (pl_s3 < pr_s3) : (pr_s3 < pl_s3);
	assign toggle = v_s3 && cand_s3 && left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			done_q <= (q_start && (n_in == '0)) || (v_s3 && last_s3);
			if (q_start) begin
				parity_q <= 1'b0;
				if (n_in == '0) begin
					inside_q <= 1'b0;
				end
			end else begin
				parity_q <= parity_q ^ toggle;
			end
			if (v_s3 && last_s3) begin
				inside_q <= parity_q ^ toggle;
			end
		end
	end

	a_walk_has_sides: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((n_q != '0) && (k_q <= n_q)))
		else $error("edge walk without sides or past the last vertex");

	a_edges_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q != ST_IDLE))
		else $error("edge in flight while the walker is idle");

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("item taken from the queue during a query");

	a_result_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && last_s3) |=> (done_q && (state_q == ST_IDLE)))
		else $error("last edge left without a result");

endmodule

// ===== hw/rtl/point_in_polygon_crossing_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_core
// Ray-crossing point-in-polygon test over a stored polygon of signed Q16.16
// vertices.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. A
// vertex item (kind 0) writes one slot of the vertex store and gives no
// result; a query item (kind 1) gives exactly one result, shown on inside_res
// for the single cycle in which done is high. The receiver cannot hold results
// off, so sample inside_res whenever done is high. Items are answered strictly
// in order. A query over n sides (polygon_sides, capped at 16) passes through
// the edge walker: one vertex is read from the single-port vertex store per
// cycle (n + 1 reads, the first fetching the closing vertex), followed by the
// difference, product and parity stages. A query with zero sides answers
// outside. A two-item queue lets the input side run ahead while a query is
// walking. Write polygon_sides through cfg_we / cfg_wdata only while the core
// is idle, and query only vertices that have been written since reset.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [pipct_pkg::SLOT_W-1:0]         vertex_slot,
	input  logic signed [pipct_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pipct_pkg::COORD_W-1:0] coord_y,
	input  logic                                 cfg_we,
	input  logic [pipct_pkg::SIDES_W-1:0]        cfg_wdata,
	output logic                                 done,
	output logic                                 inside_res
);
	import pipct_pkg::*;

	// side count in use; reset to an empty polygon
	logic [SIDES_W-1:0] sides_q;

	item_t   front_item;
	item_t   head_item;
	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sides_q <= '0;
		end else if (cfg_we) begin
			sides_q <= cfg_wdata;
		end
	end

	// take and classify items; hold one while the queue is full
	pipct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.vertex_slot (vertex_slot),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.stat        (q_stat),
		.busy        (busy),
		.push        (q_push),
		.item        (front_item)
	);

	// decouple the input side from the edge walker
	pipct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (front_item),
		.pop     (q_pop),
		.head    (head_item),
		.stat    (q_stat)
	);

	// store vertices and walk the edges of each query
	pipct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_item),
		.stat       (q_stat),
		.sides      (sides_q),
		.pop        (q_pop),
		.done       (done),
		.inside_res (inside_res)
	);

endmodule

// ===== tb/point_in_polygon_crossing_test_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_core_tb
// Self-checking bench for the ray-crossing point-in-polygon core. Vertex and
// query items are queued by the stimulus process, fed through the start/busy
// handshake by a clocked driver and predicted as they are accepted. A
// clocked monitor checks every inside_res against the oldest prediction.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test_core_tb;

	import pipct_pkg::*;

	localparam int SETTLE_CYCLES = 40;    // well beyond a 16-side walk plus queue
	localparam int STALL_LIMIT   = 5000;  // cycles with no accepted item or result
	localparam int NUM_PHASES    = 14;
	localparam int QUERIES_PER_PHASE = 26;

	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

	// Clock, reset and block ports. Every input starts at a known value.
	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        start       = 1'b0;
	logic                        busy;
	logic                        kind        = OP_VERTEX;
	logic [SLOT_W-1:0]           vertex_slot = '0;
	logic signed [COORD_W-1:0]   coord_x     = '0;
	logic signed [COORD_W-1:0]   coord_y     = '0;
	logic                        cfg_we      = 1'b0;
	logic [SIDES_W-1:0]          cfg_wdata   = '0;
	logic                        done;
	logic                        inside_res;

	// Items waiting for the driver, and the item currently on the ports.
	item_t pending[$];
	item_t cur_item;
	int    idle_pct = 0;

	// Predictor state: its own copy of the vertex store and the side count.
	logic signed [COORD_W-1:0] poly_x [MAX_SIDES];
	logic signed [COORD_W-1:0] poly_y [MAX_SIDES];
	logic [SIDES_W-1:0]        sides_reg = '0;
	bit                        inside_expected[$];

	// What the stimulus has written so far, used to aim queries at vertices.
	logic signed [COORD_W-1:0] gen_x [MAX_SIDES];
	logic signed [COORD_W-1:0] gen_y [MAX_SIDES];

	int mismatch_count = 0;
	int stall_cycles   = 0;

	point_in_polygon_crossing_test_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.vertex_slot (vertex_slot),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.inside_res  (inside_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Crossing parity of the query point against the stored polygon. The
	// crossing compare is kept exact: both sides are scaled by the edge's
	// y span, and the sign of that span picks the direction of the compare.
	// Differences need 33 bits and their products 66, so widen before use.
	function automatic bit crossing_parity(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		int                        n;
		int                        i;
		int                        j;
		bit                        odd;
		logic signed [DIFF_W-1:0]  xi, yi, xj, yj, qx, qy, dy;
		logic signed [PROD_W-1:0]  lhs, rhs;
		bit                        left;
		n   = (sides_reg > MAX_SIDES) ? MAX_SIDES : int'(sides_reg);
		odd = 1'b0;
		qx  = px;
		qy  = py;
		j   = (n > 0) ? n - 1 : 0;
		for (i = 0; i < n; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			// A horizontal edge never straddles, so it never reaches the crossing compare.
			if (((yi < qy) && (yj >= qy)) || ((yj < qy) && (yi >= qy))) begin
				if ((xi <= qx) || (xj <= qx)) begin
					dy   = yj - yi;
					lhs  = (qy - yi) * (xj - xi);
					rhs  = (qx - xi) * dy;
					left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
					if (left)
						odd = !odd;
				end
			end
			j = i;
		end
		return odd;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Driver: at each edge, predict the item just taken, then, unless busy holds the
	// current one, present the next queued item or drop start, depending on the queue and the idle setting.
	always @(posedge clk or negedge arst_n) begin : driver
		item_t nxt;
		if (!arst_n) begin
			start       <= 1'b0;
			kind        <= OP_VERTEX;
			vertex_slot <= '0;
			coord_x     <= '0;
			coord_y     <= '0;
		end else begin
			if (start && !busy) begin
				if (cur_item.op == OP_QUERY) begin
					inside_expected = {inside_expected,
						crossing_parity(cur_item.x, cur_item.y)};
				end else begin
					poly_x[cur_item.slot] = cur_item.x;
					poly_y[cur_item.slot] = cur_item.y;
				end
			end
			if (!start || !busy) begin
				if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt          = pending.pop_front();
					cur_item     = nxt;
					start       <= 1'b1;
					kind        <= nxt.op;
					vertex_slot <= nxt.slot;
					coord_x     <= nxt.x;
					coord_y     <= nxt.y;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: a result is valid only in the cycle where done is high, and
	// the core answers in order, so match it against the oldest prediction.
	always @(posedge clk) begin : monitor
		bit want;
		if (arst_n && done) begin
			if (inside_expected.size() == 0) begin
				report_mismatch($sformatf("inside_res %0b with no query outstanding",
					inside_res));
			end else begin
				want = inside_expected.pop_front();
				if (inside_res !== want)
					report_mismatch($sformatf("inside_res got %0b want %0b", inside_res, want));
			end
		end
	end

	// Watchdog: count cycles with work outstanding but nothing moving.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done ||
				(pending.size() == 0 && !start && inside_expected.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_vertex(input int slot, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		item_t it;
		it.op   = OP_VERTEX;
		it.slot = slot[SLOT_W-1:0];
		it.x    = x;
		it.y    = y;
		gen_x[slot] = x;
		gen_y[slot] = y;
		pending = {pending, it};
	endtask

	task automatic add_query(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		item_t it;
		it.op   = OP_QUERY;
		it.slot = SLOT_W'($urandom_range(MAX_SIDES - 1));  // ignored, but toggle it
		it.x    = x;
		it.y    = y;
		pending = {pending, it};
	endtask

	// Hold until every queued item is taken and every answer is back, then
	// let trailing vertex writes (which give no result) clear the core.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending.size() != 0 || start || inside_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the side count only once the core has gone quiet.
	task automatic write_sides(input logic [SIDES_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sides_reg  = value;
	endtask

	function automatic int jitter(input int centre, input int spread);
		return centre + int'($urandom_range(2 * spread)) - spread;
	endfunction

	function automatic logic signed [COORD_W-1:0] extreme_coord();
		case ($urandom_range(3))
			0:       return C_MIN;
			1:       return C_MAX;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	// Phase plan: side counts include none, the degenerate one and two, the
	// full store, and values past the store that the core must cap.
	function automatic logic [SIDES_W-1:0] sides_for_phase(input int ph);
		case (ph)
			0:       return 5'd3;
			1:       return 5'd16;
			2:       return 5'd5;
			3:       return 5'd17;
			4:       return 5'd31;
			5:       return 5'd1;
			6:       return 5'd2;
			7:       return 5'd8;
			8:       return 5'd12;
			9:       return 5'd0;
			10:      return 5'd4;
			11:      return 5'd6;
			12:      return 5'd15;
			default: return 5'd16;
		endcase
	endfunction

	// Sender idling by phase: none, heavy, and light.
	function automatic int idle_for_phase(input int ph);
		case (ph % 3)
			0:       return 0;
			1:       return 88;
			default: return 30;
		endcase
	endfunction

	initial begin : stimulus
		int  ph;
		int  k;
		int  n;
		int  v;
		int  cx;
		int  cy;
		int  span;
		bit  wide;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: no sides at reset, so any query answers outside.
		idle_pct = 0;
		add_query('0, '0);
		add_query(C_MIN, C_MAX);

		// Fill the whole store so that no later query reads an unwritten slot.
		// Slots 0..3 hold a square spanning the full coordinate range, which
		// gives both horizontal edges and the widest differences and products.
		add_vertex(0, C_MIN, C_MIN);
		add_vertex(1, C_MAX, C_MIN);
		add_vertex(2, C_MAX, C_MAX);
		add_vertex(3, C_MIN, C_MAX);
		for (k = 4; k < MAX_SIDES; k++)
			add_vertex(k, $urandom, $urandom);

		write_sides(5'd4);
		add_query('0, '0);
		add_query(C_MIN, '0);
		add_query(C_MAX, '0);
		add_query('0, C_MIN);
		add_query('0, C_MAX);
		add_query(C_MAX, C_MAX);

		// Random phases: a fresh polygon, then queries aimed at it, with the
		// odd vertex rewrite dropped in between to disturb the shape.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_sides(sides_for_phase(ph));
			idle_pct = idle_for_phase(ph);
			n    = (sides_for_phase(ph) > MAX_SIDES) ? MAX_SIDES : int'(sides_for_phase(ph));
			wide = ($urandom_range(3) == 0);
			cx   = $urandom;
			cy   = $urandom;
			span = 1 << $urandom_range(3, 28);
			for (k = 0; k < n; k++) begin
				if (wide)
					add_vertex(k, $urandom, $urandom);
				else
					add_vertex(k, jitter(cx, span), jitter(cy, span));
			end
			for (k = 0; k < QUERIES_PER_PHASE; k++) begin
				v = (n > 0) ? $urandom_range(n - 1) : 0;
				case ($urandom_range(9))
					0, 1, 2, 3, 4: add_query(jitter(cx, span), jitter(cy, span));
					// Query y on a vertex y: the straddle boundary.
					5, 6:          add_query(jitter(gen_x[v], 2), gen_y[v]);
					7:             add_query($urandom, $urandom);
					8:             add_query(extreme_coord(), extreme_coord());
					default:       add_query($urandom, gen_y[v]);
				endcase
				if ($urandom_range(9) == 0)
					add_vertex($urandom_range(MAX_SIDES - 1), jitter(cx, span),
						jitter(cy, span));
			end
		end

		// Drain: all items taken, all answers back, then a quiet tail.
		wait_drained();
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
